@@ sv/b64_pkg.sv @@
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and character mapping for the Base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam int unsigned MAX_RES = 4;                // results per input word
  localparam int unsigned IDX_W   = $clog2(MAX_RES);
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

  localparam logic       DIR_ENCODE = 1'b0;
  localparam logic       DIR_DECODE = 1'b1;
  localparam logic [7:0] PAD_CHAR   = 8'h3D;          // '='

  // One accepted input word, expanded: up to four result values.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] vals;
    logic [CNT_W-1:0]        cnt;      // 1..MAX_RES
    logic                    marker;   // data-less end marker
    logic                    msg_end;  // word closed the message
  } bundle_t;

  // 6-bit group -> alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] idx);
    logic [7:0] w;
    w = {2'b00, idx};
    if (idx < 6'd26)      return 8'h41 + w;
    else if (idx < 6'd52) return 8'h61 + w - 8'd26;
    else if (idx < 6'd62) return 8'h30 + w - 8'd52;
    else if (idx == 6'd62) return 8'h2B;
    else                  return 8'h2F;
  endfunction

  // character -> {in_alphabet, 6-bit value}
  function automatic logic [6:0] dec_char(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return {1'b1, 6'(c - 8'h41)};
    if (c >= 8'h61 && c <= 8'h7A) return {1'b1, 6'(c - 8'h61 + 8'd26)};
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 6'(c - 8'h30 + 8'd52)};
    if (c == 8'h2B)               return {1'b1, 6'd62};
    if (c == 8'h2F)               return {1'b1, 6'd63};
    return 7'd0;
  endfunction

endpackage

@@ sv/base64_codec.sv @@
// ----------------------------------------------------------------------------
// base64_codec
// Streaming Base64 codec (standard alphabet, '=' padding), queue ports.
// ----------------------------------------------------------------------------
// Both sides behave like a FIFO: push a word while full is low, pop a result
// while empty is low. cfg_direction selects encode (0) or decode (1); a write
// clears all message state, so write it only while no message is in flight.
// Encode emits one or two characters per byte, plus the zero-filled tail and
// '=' padding on the final byte (up to four results for one word). Decode
// emits at most one byte per character; a non-alphabet character (including
// '=') silences the rest of the message, and a final word that yields no byte
// produces a data-less end marker (has_value low). The front stage expands a
// word combinationally and takes one word every cycle while full is low; the
// back stage drains one result per cycle while results are popped, so the
// throughput is set by the result count: an encode word yields 1 to 4
// results (about 4/3 on average), a decode word at most one. QUEUE_DEPTH
// bundles buffer the stages; results reach the ports via the output register.
// ----------------------------------------------------------------------------
module base64_codec #(
  parameter int unsigned QUEUE_DEPTH = 4   // 2 or more
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_direction,
  // input words
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_symbol,
  input  logic       in_final_req,
  // results
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_value,
  output logic       out_has_value,
  output logic       out_run_end,
  output logic       out_message_end
);
  import b64_pkg::*;

  bundle_t bnd, head;
  logic    bnd_push, q_rd, q_empty, acc;

  // the user writes config only while idle (not enforced), so no back-pressure is needed
  assign cfg_ready = 1'b1;
  assign acc       = push && !full;

  // front: state + expansion of one word into a bundle
  b64_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_valid && cfg_ready),
    .cfg_dir (cfg_direction),
    .acc     (acc),
    .sym     (in_symbol),
    .fin     (in_final_req),
    .bnd_push(bnd_push),
    .bnd     (bnd)
  );

  // bundle queue decouples acceptance from result draining
  b64_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (bnd_push),
    .wdata  (bnd),
    .rd     (q_rd),
    .rdata  (head),
    .q_full (full),
    .q_empty(q_empty)
  );

  // back: one result per cycle into the output register, while results are popped
  b64_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_empty        (q_empty),
    .q_rd           (q_rd),
    .pop            (pop),
    .empty          (empty),
    .out_value      (out_value),
    .out_has_value  (out_has_value),
    .out_run_end    (out_run_end),
    .out_message_end(out_message_end)
  );

endmodule

@@ sv/b64_front.sv @@
// ----------------------------------------------------------------------------
// b64_front
// Holds direction and message state; turns each accepted word into a bundle
// of up to four results combinationally.
// ----------------------------------------------------------------------------
module b64_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr,
  input  logic             cfg_dir,
  input  logic             acc,
  input  logic [7:0]       sym,
  input  logic             fin,
  output logic             bnd_push,
  output b64_pkg::bundle_t bnd
);
  import b64_pkg::*;

  logic        dir_r;
  logic [15:0] buf_r, buf_nxt;
  logic [3:0]  pend_r, pend_nxt;
  logic [1:0]  cmf_r, cmf_nxt;
  logic        halt_r, halt_nxt;

  always_comb begin
    logic [15:0] be, bd;
    logic [3:0]  p8, p1, p2, pd;
    logic        e0, e1, lf, emit;
    logic [5:0]  c0, c1, cl;
    logic [1:0]  pos, cmf_a, pad_want;
    logic [2:0]  nch, room, npad;
    logic [6:0]  cv;

    be       = '0;
    bd       = '0;
    p8       = '0;
    p1       = '0;
    p2       = '0;
    pd       = '0;
    e0       = 1'b0;
    e1       = 1'b0;
    lf       = 1'b0;
    emit     = 1'b0;
    c0       = '0;
    c1       = '0;
    cl       = '0;
    pos      = '0;
    cmf_a    = '0;
    pad_want = '0;
    nch      = '0;
    room     = '0;
    npad     = '0;
    cv       = '0;

    buf_nxt  = buf_r;
    pend_nxt = pend_r;
    cmf_nxt  = cmf_r;
    halt_nxt = halt_r;
    bnd      = '0;
    bnd.msg_end = fin;

    if (dir_r == DIR_ENCODE) begin
      be = {buf_r[7:0], sym};
      p8 = pend_r + 4'd8;
      e0 = (p8 >= 4'd6);
      p1 = e0 ? p8 - 4'd6 : p8;
      e1 = e0 && (p1 >= 4'd6);
      p2 = e1 ? p1 - 4'd6 : p1;
      c0 = 6'(be >> p1);
      c1 = 6'(be >> p2);
      lf = fin && (p2 != 4'd0) && (p2 < 4'd6);
      cl = 6'(be << (4'd6 - p2));
      nch = 3'(e0) + 3'(e1) + 3'(lf);
      cmf_a = cmf_r + 2'(nch);
      pad_want = 2'd0 - cmf_a;
      room = 3'(MAX_RES) - nch;
      npad = fin ? ((3'(pad_want) < room) ? 3'(pad_want) : room) : 3'd0;
      for (int k = 0; k < MAX_RES; k++) bnd.vals[k] = PAD_CHAR;
      pos = 2'd0;
      if (e0) begin
        bnd.vals[pos] = enc_char(c0);
        pos = pos + 2'd1;
      end
      if (e1) begin
        bnd.vals[pos] = enc_char(c1);
        pos = pos + 2'd1;
      end
      if (lf) begin
        bnd.vals[pos] = enc_char(cl);
      end
      bnd.cnt  = CNT_W'(nch + npad);
      buf_nxt  = be;
      pend_nxt = p2;
      cmf_nxt  = cmf_a + 2'(npad);
    end else begin
      cv   = dec_char(sym);
      emit = 1'b0;
      bd   = buf_r;
      pd   = pend_r;
      if (!halt_r) begin
        if (!cv[6]) begin
          halt_nxt = 1'b1;
        end else begin
          bd = {buf_r[9:0], cv[5:0]};
          pd = pend_r + 4'd6;
          if (pd >= 4'd8) begin
            pd   = pd - 4'd8;
            emit = 1'b1;
          end
          buf_nxt  = bd;
          pend_nxt = pd;
        end
      end
      bnd.vals[0] = emit ? 8'(bd >> pd) : 8'h00;
      bnd.marker  = fin && !emit;
      bnd.cnt     = (emit || fin) ? CNT_W'(1) : '0;
    end

    if (fin) begin
      buf_nxt  = '0;
      pend_nxt = '0;
      cmf_nxt  = '0;
      halt_nxt = 1'b0;
    end
  end

  assign bnd_push = acc && (bnd.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= DIR_ENCODE;
      buf_r  <= '0;
      pend_r <= '0;
      cmf_r  <= '0;
      halt_r <= 1'b0;
    end else if (cfg_wr) begin
      dir_r  <= cfg_dir;
      buf_r  <= '0;
      pend_r <= '0;
      cmf_r  <= '0;
      halt_r <= 1'b0;
    end else if (acc) begin
      buf_r  <= buf_nxt;
      pend_r <= pend_nxt;
      cmf_r  <= cmf_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

@@ sv/b64_queue.sv @@
// ----------------------------------------------------------------------------
// b64_queue
// Small bundle FIFO between front and back.
// ----------------------------------------------------------------------------
module b64_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  b64_pkg::bundle_t wdata,
  input  logic             rd,
  output b64_pkg::bundle_t rdata,
  output logic             q_full,
  output logic             q_empty
);
  import b64_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bundle_t       mem [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rdata   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (rd) rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      if (wr && !rd)      cnt_r <= cnt_r + CW'(1);
      else if (rd && !wr) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

@@ sv/b64_back.sv @@
// ----------------------------------------------------------------------------
// b64_back
// Serializes the head bundle into single results through an output register,
// one per cycle while the output is popped.
// ----------------------------------------------------------------------------
module b64_back (
  input  logic             clk,
  input  logic             rst_n,
  input  b64_pkg::bundle_t head,
  input  logic             q_empty,
  output logic             q_rd,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_value,
  output logic             out_has_value,
  output logic             out_run_end,
  output logic             out_message_end
);
  import b64_pkg::*;

  logic [IDX_W-1:0] idx_r;
  logic             vld_r;
  logic             ld, last;

  assign ld    = !q_empty && (!vld_r || pop);
  assign last  = (CNT_W'(idx_r) + CNT_W'(1) == head.cnt);
  assign q_rd  = ld && last;
  assign empty = !vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (ld)       vld_r <= 1'b1;
      else if (pop) vld_r <= 1'b0;
      if (ld) idx_r <= last ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_value       <= head.vals[idx_r];
      out_has_value   <= !head.marker;
      out_run_end     <= last;
      out_message_end <= last && head.msg_end;
    end
  end

endmodule

@@ sv/b64_checker.sv @@
// ----------------------------------------------------------------------------
// b64_checker
// Port-level checks on the codec's result channel.
// ----------------------------------------------------------------------------
module b64_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_value,
  input logic       out_has_value,
  input logic       out_run_end,
  input logic       out_message_end
);

  // a waiting word holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_value) && $stable(out_run_end)))
    else $error("result word changed while stalled");

  // end marker is always the last word of its message
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_has_value) |-> (out_run_end && out_message_end))
    else $error("end marker not closing message");

  // message end only on the last word of a run
  a_msg_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_message_end) |-> out_run_end)
    else $error("message end without run end");

  // reset leaves nothing to pop
  a_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("results present after reset");

endmodule

bind base64_codec b64_checker u_chk (.*);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for base64_codec. A short stimulus table exercises
// padding, halting and end markers, then random encode and decode messages
// follow. Results are compared to an in-bench Base64 model or typed row values.
// ----------------------------------------------------------------------------
module tb;
  import b64_pkg::*;

  localparam int CYCLE_LIMIT = 300000;    // far above the slowest legal run
  localparam int RAND_WORDS  = 75;
  localparam int SETTLE      = 6;         // push-to-result latency plus margin

  // Standard alphabet, first character in the top byte.
  localparam logic [511:0] ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] value;
    logic       has_value;
    logic       run_end;
    logic       message_end;
  } res_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // tv/th: first result of the row, typed in where it is obvious
  typedef struct packed {
    row_kind_t  kind;
    logic       dir;
    logic [7:0] sym;
    logic       fin;
    logic       typed;
    logic [7:0] tv;
    logic       th;
  } row_t;

  localparam int PLAN_LEN = 26;

  row_t plan [PLAN_LEN] = '{
    // encode, from the reset value of the direction
    '{ROW_WORD, DIR_ENCODE, 8'h00, 1'b1, 1'b1, 8'h41, 1'b1},  // "AA=="
    '{ROW_WORD, DIR_ENCODE, 8'hFF, 1'b1, 1'b1, 8'h2F, 1'b1},  // "/w=="
    '{ROW_WORD, DIR_ENCODE, 8'h4D, 1'b0, 1'b1, 8'h54, 1'b1},  // "Man" -> "TWFu"
    '{ROW_WORD, DIR_ENCODE, 8'h61, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_WORD, DIR_ENCODE, 8'h6E, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_WORD, DIR_ENCODE, 8'h66, 1'b0, 1'b1, 8'h5A, 1'b1},  // "fo" -> "Zm8="
    '{ROW_WORD, DIR_ENCODE, 8'h6F, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ROW_WORD, DIR_ENCODE, 8'h80, 1'b0, 1'b1, 8'h67, 1'b1},  // message left open
    '{ROW_CFG,  DIR_ENCODE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},  // write clears it
    '{ROW_WORD, DIR_ENCODE, 8'h01, 1'b1, 1'b1, 8'h41, 1'b1},
    // decode
    '{ROW_CFG,  DIR_DECODE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ROW_WORD, DIR_DECODE, 8'h54, 1'b0, 1'b0, 8'h00, 1'b0},  // 'T', no byte yet
    '{ROW_WORD, DIR_DECODE, 8'h57, 1'b0, 1'b1, 8'h4D, 1'b1},  // 'W'
    '{ROW_WORD, DIR_DECODE, 8'h46, 1'b0, 1'b0, 8'h00, 1'b0},  // 'F'
    '{ROW_WORD, DIR_DECODE, 8'h75, 1'b1, 1'b0, 8'h00, 1'b0},  // 'u'
    '{ROW_WORD, DIR_DECODE, 8'h3D, 1'b1, 1'b1, 8'h00, 1'b0},  // lone pad: marker
    '{ROW_WORD, DIR_DECODE, 8'h41, 1'b1, 1'b1, 8'h00, 1'b0},  // 6 bits: marker
    '{ROW_WORD, DIR_DECODE, 8'h5A, 1'b0, 1'b0, 8'h00, 1'b0},  // 'Z'
    '{ROW_WORD, DIR_DECODE, 8'h6D, 1'b0, 1'b0, 8'h00, 1'b0},  // 'm'
    '{ROW_WORD, DIR_DECODE, 8'h38, 1'b0, 1'b0, 8'h00, 1'b0},  // '8'
    '{ROW_WORD, DIR_DECODE, 8'h3D, 1'b0, 1'b0, 8'h00, 1'b0},  // pad halts
    '{ROW_WORD, DIR_DECODE, 8'h2F, 1'b0, 1'b0, 8'h00, 1'b0},  // ignored
    '{ROW_WORD, DIR_DECODE, 8'h41, 1'b1, 1'b1, 8'h00, 1'b0},  // halted: marker
    '{ROW_WORD, DIR_DECODE, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0},  // non-alphabet
    '{ROW_WORD, DIR_DECODE, 8'h2B, 1'b0, 1'b0, 8'h00, 1'b0},  // '+'
    '{ROW_WORD, DIR_DECODE, 8'h2F, 1'b1, 1'b1, 8'hFB, 1'b1}   // '/'
  };

  // DUT inputs, all known from time zero
  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       cfg_valid     = 1'b0;
  logic       cfg_direction = 1'b0;
  logic       push          = 1'b0;
  logic [7:0] in_symbol     = 8'h00;
  logic       in_final_req  = 1'b0;
  logic       pop           = 1'b0;
  logic       cfg_ready;
  logic       full;
  logic       empty;
  logic [7:0] out_value;
  logic       out_has_value;
  logic       out_run_end;
  logic       out_message_end;

  // model state
  logic        m_dir;
  logic [15:0] m_buf;
  logic [3:0]  m_pend;
  logic [1:0]  m_mod;
  logic        m_halt;

  res_t out_due [$];       // result words still owed by the block

  int errors     = 0;
  int cycles     = 0;
  int words_in   = 0;
  int words_out  = 0;
  int cfg_writes = 0;
  int msgs_enc   = 0;
  int msgs_dec   = 0;

  // per-phase idling switches; a quiet side inserts no random gaps
  logic in_quiet  = 1'b0;
  logic out_quiet = 1'b0;

  base64_codec uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_direction   (cfg_direction),
    .push            (push),
    .full            (full),
    .in_symbol       (in_symbol),
    .in_final_req    (in_final_req),
    .empty           (empty),
    .pop             (pop),
    .out_value       (out_value),
    .out_has_value   (out_has_value),
    .out_run_end     (out_run_end),
    .out_message_end (out_message_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: any hang ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d result words outstanding", $time, out_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model --

  function automatic logic [7:0] sextet_char(input logic [5:0] idx);
    return ALPHA[8*(63-idx) +: 8];
  endfunction

  // {in_alphabet, value}; found by scanning the alphabet
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (ALPHA[8*(63-i) +: 8] == c) return {1'b1, 6'(i)};
    end
    return 7'd0;
  endfunction

  function automatic void msg_clear();
    m_buf  = '0;
    m_pend = '0;
    m_mod  = '0;
    m_halt = 1'b0;
  endfunction

  function automatic void due_push(input logic [7:0] v, input logic h);
    res_t r;
    r.value       = v;
    r.has_value   = h;
    r.run_end     = 1'b0;
    r.message_end = 1'b0;
    out_due = {out_due, r};
  endfunction

  // Expand one accepted input word into the result words it causes.
  function automatic void codec_expand(input logic [7:0] sym, input logic fin);
    int          n;
    int          sh;
    logic [15:0] t;
    logic [6:0]  dv;
    res_t        r;
    n = 0;
    if (m_dir == DIR_ENCODE) begin
      m_buf  = {m_buf[7:0], sym};
      m_pend = m_pend + 4'd8;
      while (m_pend >= 4'd6 && n < MAX_RES) begin
        m_pend = m_pend - 4'd6;
        t = m_buf >> m_pend;
        due_push(sextet_char(t[5:0]), 1'b1);
        m_mod = m_mod + 2'd1;
        n++;
      end
      if (fin) begin
        // zero-filled tail character, then pad to a multiple of four
        if (m_pend > 4'd0 && m_pend < 4'd6 && n < MAX_RES) begin
          sh = 6 - m_pend;
          t = m_buf << sh;
          due_push(sextet_char(t[5:0]), 1'b1);
          m_mod = m_mod + 2'd1;
          n++;
        end
        while (m_mod != 2'd0 && n < MAX_RES) begin
          due_push(PAD_CHAR, 1'b1);
          m_mod = m_mod + 2'd1;
          n++;
        end
      end
    end else begin
      if (!m_halt) begin
        dv = char_sextet(sym);
        if (!dv[6]) begin
          m_halt = 1'b1;
        end else begin
          m_buf  = {m_buf[9:0], dv[5:0]};
          m_pend = m_pend + 4'd6;
          if (m_pend >= 4'd8) begin
            m_pend = m_pend - 4'd8;
            t = m_buf >> m_pend;
            due_push(t[7:0], 1'b1);
            n++;
          end
        end
      end
      if (fin && n == 0) begin
        due_push(8'h00, 1'b0);   // end marker
        n++;
      end
    end
    if (n > 0) begin
      r = out_due[out_due.size() - 1];
      r.run_end     = 1'b1;
      r.message_end = fin;
      out_due[out_due.size() - 1] = r;
    end
    if (fin) msg_clear();
  endfunction

  // -------------------------------------------------------------- drivers --

  // Offer one word; returns in the step at which it was accepted, push high.
  task automatic send_word(input logic [7:0] sym, input logic fin, input logic typed,
                           input logic [7:0] tv, input logic th);
    int   gap;
    int   base;
    res_t r;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    in_symbol    <= sym;
    in_final_req <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    base = out_due.size();
    codec_expand(sym, fin);
    // typed rows take their first result from the table
    if (typed && out_due.size() > base) begin
      r = out_due[base];
      r.value     = tv;
      r.has_value = th;
      out_due[base] = r;
    end
    words_in++;
  endtask

  // Wait for the block to drain, then write the direction register.
  task automatic write_direction(input logic d);
    push <= 1'b0;
    while (out_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);   // words with no result may still be inside
    cfg_valid     <= 1'b1;
    cfg_direction <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    m_dir = d;
    msg_clear();
    cfg_writes++;
  endtask

  // Result side: random stall per word, then pop and check against the model.
  initial begin
    int   stall;
    res_t got;
    res_t want;
    wait (rst_n);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got = '{out_value, out_has_value, out_run_end, out_message_end};
      words_out++;
      if (out_due.size() == 0) begin
        $display("%0t: unexpected result word: value=%02h has=%b run_end=%b msg_end=%b",
                 $time, got.value, got.has_value, got.run_end, got.message_end);
        errors++;
      end else begin
        want = out_due.pop_front();
        if (got.value !== want.value || got.has_value !== want.has_value ||
            got.run_end !== want.run_end || got.message_end !== want.message_end) begin
          $display("%0t: mismatch: expected %02h/%b/%b/%b got %02h/%b/%b/%b",
                   $time, want.value, want.has_value, want.run_end, want.message_end,
                   got.value, got.has_value, got.run_end, got.message_end);
          errors++;
        end
      end
    end
  end

  // ------------------------------------------------------------- stimulus --

  initial begin
    int         rand_words;
    int         len;
    int         pads;
    logic       noisy;
    logic       pdir;
    logic       fin;
    logic [7:0] sym;

    m_dir = DIR_ENCODE;    // reset value
    msg_clear();
    rand_words = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: padding lengths, open message cleared by a write,
    // decode halting on pad and on non-alphabet bytes, end markers.
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        write_direction(plan[i].dir);
      end else begin
        send_word(plan[i].sym, plan[i].fin, plan[i].typed, plan[i].tv, plan[i].th);
      end
    end

    // Random phases: each picks a direction and idling style, then sends a
    // few whole messages. Decode is mostly well-formed text, some pads at the
    // tail, with an occasional noisy message to hit the halt path.
    while (rand_words < RAND_WORDS) begin
      pdir = 1'($urandom_range(0, 1));
      write_direction(pdir);
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 4)) begin
        len   = $urandom_range(1, 6);
        noisy = (pdir == DIR_DECODE) && ($urandom_range(0, 4) == 0);
        pads  = (pdir == DIR_DECODE) ? $urandom_range(0, 2) : 0;
        if (pdir == DIR_ENCODE) msgs_enc++;
        else msgs_dec++;
        for (int k = 0; k < len; k++) begin
          fin = (k == len - 1);
          if (pdir == DIR_ENCODE || (noisy && $urandom_range(0, 2) == 0)) begin
            sym = 8'($urandom_range(0, 255));
          end else if (k >= len - pads) begin
            sym = PAD_CHAR;
          end else begin
            sym = sextet_char(6'($urandom_range(0, 63)));
          end
          send_word(sym, fin, 1'b0, 8'h00, 1'b0);
          rand_words++;
        end
      end
    end

    // Drain, then give the block time to show any extra word.
    push <= 1'b0;
    while (out_due.size() != 0) @(posedge clk);
    repeat (4 * SETTLE) @(posedge clk);

    $display("Covered %0d input words (%0d random; %0d encode and %0d decode messages)",
             words_in, rand_words, msgs_enc, msgs_dec);
    $display("%0d direction writes, %0d result words compared, %0d errors",
             cfg_writes, words_out, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
